/* src/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// btpc_pkg
// types and constants shared by the barometric compensation pipeline
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned CfgWidth   = 48;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned DivW       = 32;

  localparam logic [CfgIdxW-1:0] RegTemp   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressA = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressB = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressC = 2'd3;

  localparam logic [31:0] POffset   = 32'd64000;
  localparam logic [31:0] PFull     = 32'd1048576;
  localparam logic [31:0] PScale    = 32'd3125;
  localparam logic [31:0] PHalf     = 32'h8000_0000;
  localparam logic [31:0] POne      = 32'd32768;
  localparam logic [31:0] TRound    = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_pa;
    logic               pressure_invalid;
  } out_item_t;

  // values travelling down the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        big;
    logic        invalid;
  } div_side_t;

  function automatic logic [31:0] sword(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

/* src/btpc_divider.sv */
// ----------------------------------------------------------------------------
// btpc_divider
// pipelined restoring divider, one quotient bit per stage, stall by enable
// ----------------------------------------------------------------------------
module btpc_divider (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            num_i,
  input  logic [31:0]            den_i,
  input  btpc_pkg::div_side_t    side_i,
  output logic                   valid_o,
  output logic [31:0]            quo_o,
  output btpc_pkg::div_side_t    side_o
);

  localparam int unsigned N = btpc_pkg::DivW;

  logic [N:0]                valid_q;
  logic [N:0][31:0]          rem_q;
  logic [N:0][31:0]          num_q;
  logic [N:0][31:0]          den_q;
  btpc_pkg::div_side_t [N:0] side_q;

  assign valid_q[0] = valid_i;
  assign rem_q[0]   = '0;
  assign num_q[0]   = num_i;
  assign den_q[0]   = den_i;
  assign side_q[0]  = side_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [32:0] trial;
    logic [31:0] rem_d;
    logic [31:0] num_d;
    logic        bit_d;
    logic        v_r;
    logic [31:0] rem_r, num_r, den_r;
    btpc_pkg::div_side_t side_r;

    always_comb begin
      trial = {rem_q[s], num_q[s][31]};
      bit_d = (trial >= {1'b0, den_q[s]});
      rem_d = bit_d ? 32'(trial - {1'b0, den_q[s]}) : trial[31:0];
      num_d = {num_q[s][30:0], bit_d};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r <= 1'b0;
      end else if (en_i) begin
        v_r <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        num_r  <= num_d;
        den_r  <= den_q[s];
        side_r <= side_q[s];
      end
    end

    assign valid_q[s+1] = v_r;
    assign rem_q[s+1]   = rem_r;
    assign num_q[s+1]   = num_r;
    assign den_q[s+1]   = den_r;
    assign side_q[s+1]  = side_r;
  end

  assign valid_o = valid_q[N];
  assign quo_o   = num_q[N];
  assign side_o  = side_q[N];

endmodule

/* src/baro_temp_press_compensation.sv */
// throughput: one request per cycle; the whole pipeline advances when the
// output register is free or being taken, so a stall holds every stage
// reset: rst_ni clears all valid bits and the four calibration registers to 0
// ----------------------------------------------------------------------------
// baro_temp_press_compensation
// 32-bit integer temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
module baro_temp_press_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [47:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btpc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btpc_pkg::out_item_t  out_data_o
);

  logic [47:0] tc_q, pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btpc_pkg::RegTemp:   tc_q <= cfg_data_i;
        btpc_pkg::RegPressA: pa_q <= cfg_data_i;
        btpc_pkg::RegPressB: pb_q <= cfg_data_i;
        btpc_pkg::RegPressC: pc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'h0, tc_q[15:0]};
  assign t2 = btpc_pkg::sword(tc_q[31:16]);
  assign t3 = btpc_pkg::sword(tc_q[47:32]);
  assign p1 = {16'h0, pa_q[15:0]};
  assign p2 = btpc_pkg::sword(pa_q[31:16]);
  assign p3 = btpc_pkg::sword(pa_q[47:32]);
  assign p4 = btpc_pkg::sword(pb_q[15:0]);
  assign p5 = btpc_pkg::sword(pb_q[31:16]);
  assign p6 = btpc_pkg::sword(pb_q[47:32]);
  assign p7 = btpc_pkg::sword(pc_q[15:0]);
  assign p8 = btpc_pkg::sword(pc_q[31:16]);
  assign p9 = btpc_pkg::sword(pc_q[47:32]);

  // global advance: output register empty or being taken
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- temperature stages
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q, ap6_q, ap7_q, ap8_q;
  logic [31:0] tx_q, d_q;
  logic [31:0] ta_q, dd_q;
  logic [31:0] ta2_q, tb_q;
  logic [31:0] fine3_q;
  logic [31:0] fine4_q, f5_q;
  logic [31:0] temp5_q, a5_q, q5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <= '0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
    end
  end

  logic [31:0] adc_t;
  assign adc_t = {12'h0, in_data_i.raw_temperature};

  // pressure stage registers
  logic [31:0] temp6_q, fine6_q, temp7_q, fine7_q, temp8_q, fine8_q;
  logic [31:0] qq6_q, ap56_q, p2a6_q;
  logic [31:0] b7_q, a7_q;
  logic [31:0] b8_q, dv8_q;
  logic [31:0] qa8_q;
  logic [31:0] qq13;
  logic [31:0] p3qq7_q, a7c;
  logic [31:0] b7c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap1_q <= in_data_i.raw_pressure;
      tx_q  <= (adc_t >> 3) - (t1 << 1);
      d_q   <= (adc_t >> 4) - t1;
      // multiply
      ap2_q <= ap1_q;
      ta_q  <= 32'(tx_q * t2);
      dd_q  <= 32'(d_q * d_q);
      ap3_q <= ap2_q;
      ta2_q <= btpc_pkg::asr(ta_q, 11);
      tb_q  <= 32'(btpc_pkg::asr(dd_q, 12) * t3);
      ap4_q <= ap3_q;
      fine3_q <= ta2_q + btpc_pkg::asr(tb_q, 14);
      ap5_q <= ap4_q;
      fine4_q <= fine3_q;
      f5_q    <= 32'(fine3_q * 32'd5);
      // stage 5: temperature and pressure start
      ap6_q   <= ap5_q;
      temp5_q <= btpc_pkg::asr(f5_q + btpc_pkg::TRound, 8);
      a5_q    <= btpc_pkg::asr(fine4_q, 1) - btpc_pkg::POffset;
      q5_q    <= btpc_pkg::asr(btpc_pkg::asr(fine4_q, 1) - btpc_pkg::POffset, 2);
      fine6_q <= fine4_q;
      // stage 6: products
      ap7_q   <= ap6_q;
      temp6_q <= temp5_q;
      fine7_q <= fine6_q;
      qq6_q   <= 32'(q5_q * q5_q);
      ap56_q  <= 32'(a5_q * p5);
      p2a6_q  <= 32'(p2 * a5_q);
      // stage 7
      ap8_q   <= ap7_q;
      temp7_q <= temp6_q;
      fine8_q <= fine7_q;
      b7_q    <= 32'(btpc_pkg::asr(qq6_q, 11) * p6);
      a7_q    <= ap56_q << 1;
      p3qq7_q <= 32'(p3 * qq13);
      dv8_q   <= p2a6_q;
      // stage 8
      temp8_q <= temp7_q;
      b8_q    <= b7c;
      qa8_q   <= btpc_pkg::asr(a7c, 18);
    end
  end
  assign qq13 = btpc_pkg::asr(qq6_q, 13);
  assign a7c  = btpc_pkg::asr(p3qq7_q, 3) + btpc_pkg::asr(dv8_q, 1);
  assign b7c  = btpc_pkg::asr(b7_q + a7_q, 2) + (p4 << 16);

  // stage 9: divisor product and numerator
  logic        v9_q, v10_q, v11_q;
  logic [19:0] ap9_q;
  logic [31:0] dp9_q, nm9_q, t9_q, f9_q;
  logic [31:0] dv10_q, nm10_q, t10_q, f10_q;
  logic [31:0] fine9src_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fine9src_q <= fine8_q;
      ap9_q  <= ap8_q;
      dp9_q  <= 32'((btpc_pkg::POne + qa8_q) * p1);
      nm9_q  <= (btpc_pkg::PFull - {12'h0, ap9_q}) - btpc_pkg::asr(b8_q, 12);
      t9_q   <= temp8_q;
      f9_q   <= fine9src_q;
      dv10_q <= btpc_pkg::asr(dp9_q, 15);
      nm10_q <= 32'(nm9_q * btpc_pkg::PScale);
      t10_q  <= t9_q;
      f10_q  <= f9_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0;
    end else if (en) begin
      v9_q <= v8_q; v10_q <= v9_q; v11_q <= v10_q;
    end
  end

  // fine8_q runs ahead of temp8_q; fine9src_q realigns it
  logic                big;
  btpc_pkg::div_side_t side_in, side_out;
  logic                dvalid;
  logic [31:0]         quo;
  assign big = (nm10_q >= btpc_pkg::PHalf);
  always_comb begin
    side_in.temp    = t10_q;
    side_in.fine    = f10_q;
    side_in.big     = big;
    side_in.invalid = (dv10_q == '0);
  end

  btpc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v11_q),
    .num_i   (big ? nm10_q : (nm10_q << 1)),
    .den_i   (dv10_q),
    .side_i  (side_in),
    .valid_o (dvalid),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // correction stages
  logic        c1v_q, c2v_q;
  logic [31:0] pr1_q, sq1_q, pb1_q, pr2_q, pa2_q, pb2_q;
  btpc_pkg::div_side_t s1_q, s2_q;
  logic [31:0] pr_raw, pr2c;
  assign pr_raw = side_out.big ? (quo << 1) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1v_q <= 1'b0; c2v_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (en) begin
      c1v_q <= dvalid; c2v_q <= c1v_q; out_valid_o <= c2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr1_q <= pr_raw;
      sq1_q <= 32'((pr_raw >> 3) * (pr_raw >> 3));
      pb1_q <= 32'((pr_raw >> 2) * p8);
      s1_q  <= side_out;
      pr2_q <= pr1_q;
      pa2_q <= 32'(p9 * (sq1_q >> 13));
      pb2_q <= pb1_q;
      s2_q  <= s1_q;
      out_data_o.temperature_centi <= s2_q.temp;
      out_data_o.fine_temperature  <= s2_q.fine;
      out_data_o.pressure_invalid  <= s2_q.invalid;
      out_data_o.pressure_pa       <= s2_q.invalid ? '0 : pr2c;
    end
  end
  assign pr2c = pr2_q + btpc_pkg::asr(btpc_pkg::asr(pa2_q, 12)
                + btpc_pkg::asr(pb2_q, 13) + p7, 4);

endmodule

/* src/btpc_checker.sv */
// ----------------------------------------------------------------------------
// btpc_checker
// port-level checks for the compensation pipeline
// ----------------------------------------------------------------------------
module btpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input btpc_pkg::out_item_t out_data_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // the pipeline advances exactly when the output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output state");

  // invalid pressure reads zero
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pressure_invalid |-> out_data_o.pressure_pa == '0)
    else $error("invalid pressure not zero");

endmodule

bind baro_temp_press_compensation btpc_checker u_btpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* bench/baro_temp_press_compensation_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_tb
// drives raw temperature and pressure pairs through the compensation pipeline
// under several calibration sets and checks every result against an
// independent 32-bit wrapping predictor, with random stalls on both sides
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_tb;

  localparam int unsigned Latency  = 46;
  localparam int unsigned WatchLim = 20000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [47:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  btpc_pkg::in_item_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  btpc_pkg::out_item_t  out_data_o;

  baro_temp_press_compensation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // calibration shadow
  logic [47:0] cal [4];

  btpc_pkg::out_item_t comp_pending [$];
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_recv;
  int unsigned n_invalid;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          sending;

  function automatic logic [31:0] sx(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic btpc_pkg::out_item_t compensate(input btpc_pkg::in_item_t it);
    btpc_pkg::out_item_t r;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] at, ap, a, b, d, q, fine, num, dv, pr;
    t1 = {16'd0, cal[btpc_pkg::RegTemp][15:0]};
    t2 = sx(cal[btpc_pkg::RegTemp][31:16]);
    t3 = sx(cal[btpc_pkg::RegTemp][47:32]);
    p1 = {16'd0, cal[btpc_pkg::RegPressA][15:0]};
    p2 = sx(cal[btpc_pkg::RegPressA][31:16]);
    p3 = sx(cal[btpc_pkg::RegPressA][47:32]);
    p4 = sx(cal[btpc_pkg::RegPressB][15:0]);
    p5 = sx(cal[btpc_pkg::RegPressB][31:16]);
    p6 = sx(cal[btpc_pkg::RegPressB][47:32]);
    p7 = sx(cal[btpc_pkg::RegPressC][15:0]);
    p8 = sx(cal[btpc_pkg::RegPressC][31:16]);
    p9 = sx(cal[btpc_pkg::RegPressC][47:32]);
    at = {12'd0, it.raw_temperature};
    ap = {12'd0, it.raw_pressure};
    a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    r.temperature_centi = sra(fine * 32'd5 + 32'd128, 8);
    r.fine_temperature = fine;
    a = sra(fine, 1) - 32'd64000;
    q = sra(a, 2);
    b = sra(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
    dv = sra((32'd32768 + a) * p1, 15);
    r.pressure_invalid = (dv == 32'd0);
    if (dv == 32'd0) begin
      pr = 32'd0;
    end else begin
      num = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
      if (num < 32'h8000_0000) pr = (num << 1) / dv;
      else pr = (num / dv) * 32'd2;
      a = sra(p9 * (((pr >> 3) * (pr >> 3)) >> 13), 12);
      b = sra((pr >> 2) * p8, 13);
      pr = pr + sra(a + b + p7, 4);
    end
    r.pressure_pa = pr;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one write, then cfg_we_i is dropped before returning so back-to-back writes never collide
  task automatic write_cal(input logic [1:0] idx, input logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cal[idx] = val;
    @(posedge clk_i);
  endtask

  // waits for the pipe to drain, then lets the latency pass before a write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (comp_pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // one request; expectation taken at acceptance with the current calibration
  task automatic send_pair(input btpc_pkg::in_item_t it, input bit use_gap);
    int unsigned g;
    if (use_gap) begin
      g = gap_len();
      if (g != 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    comp_pending.push_back(compensate(it));
    n_sent++;
  endtask

  task automatic send_burst(input btpc_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    comp_pending.push_back(compensate(it));
    n_sent++;
  endtask

  function automatic btpc_pkg::in_item_t rand_pair();
    btpc_pkg::in_item_t it;
    int unsigned k;
    k = $urandom_range(0, 9);
    it.raw_temperature = 20'($urandom_range(0, 20'hFFFFF));
    it.raw_pressure    = 20'($urandom_range(0, 20'hFFFFF));
    // mostly realistic readings, the rest anywhere
    if (k < 7) begin
      it.raw_temperature = 20'($urandom_range(400000, 600000));
      it.raw_pressure    = 20'($urandom_range(250000, 450000));
    end
    return it;
  endfunction

  // datasheet example set
  localparam logic [47:0] CalTypT = {16'hFC18, 16'h6689, 16'd27504};
  localparam logic [47:0] CalTypA = {16'd3024, 16'hD4BC, 16'd36477};
  localparam logic [47:0] CalTypB = {16'hFF9C, 16'd140, 16'd2855};
  localparam logic [47:0] CalTypC = {16'd6000, 16'hC3C8, 16'd15};

  typedef struct {
    btpc_pkg::in_item_t  stim;
    bit                  known;
    btpc_pkg::out_item_t want;
  } vec_t;

  vec_t vecs [$];

  // receiver
  initial begin
    int unsigned g;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // checker and watchdog
  always @(posedge clk_i) begin
    btpc_pkg::out_item_t w;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLim) begin
        $display("%0t watchdog: no request moved", $time);
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        n_recv++;
        if (comp_pending.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          w = comp_pending.pop_front();
          if (out_data_o.pressure_invalid) n_invalid++;
          if (out_data_o.temperature_centi !== w.temperature_centi) begin
            $display("%0t temperature exp %0d got %0d", $time,
                     w.temperature_centi, out_data_o.temperature_centi);
            errors++;
          end
          if (out_data_o.fine_temperature !== w.fine_temperature) begin
            $display("%0t fine temp exp %0d got %0d", $time,
                     w.fine_temperature, out_data_o.fine_temperature);
            errors++;
          end
          if (out_data_o.pressure_pa !== w.pressure_pa) begin
            $display("%0t pressure exp %0d got %0d", $time,
                     w.pressure_pa, out_data_o.pressure_pa);
            errors++;
          end
          if (out_data_o.pressure_invalid !== w.pressure_invalid) begin
            $display("%0t invalid flag exp %0b got %0b", $time,
                     w.pressure_invalid, out_data_o.pressure_invalid);
            errors++;
          end
        end
      end
    end
  end

  task automatic run_vecs();
    btpc_pkg::out_item_t got;
    foreach (vecs[i]) begin
      got = compensate(vecs[i].stim);
      // typed rows must agree with the predictor too
      if (vecs[i].known && got !== vecs[i].want) begin
        $display("%0t row %0d exp %p got %p", $time, i, vecs[i].want, got);
        errors++;
      end
      send_pair(vecs[i].stim, 1'b1);
    end
  endtask

  task automatic random_phase(input int unsigned n);
    repeat (n) send_pair(rand_pair(), 1'b1);
  endtask

  initial begin
    vec_t v;
    errors = 0; n_sent = 0; n_recv = 0; n_invalid = 0; idle_cycles = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = btpc_pkg::RegTemp; cfg_data_i = '0;
    in_valid_i = 1'b0; in_data_i = '0;
    foreach (cal[i]) cal[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset all coefficients are zero: everything zero, pressure invalid
    v.known = 1'b1;
    v.want = '{temperature_centi: 32'sd0, fine_temperature: 32'sd0,
               pressure_pa: 32'd0, pressure_invalid: 1'b1};
    v.stim = '{raw_temperature: 20'd0, raw_pressure: 20'd0};       vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF}; vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hAAAAA, raw_pressure: 20'h55555}; vecs.push_back(v);
    run_vecs();
    vecs.delete();
    drain();

    // typical calibration, extremes of the raw fields
    write_cal(btpc_pkg::RegTemp, CalTypT);
    write_cal(btpc_pkg::RegPressA, CalTypA);
    write_cal(btpc_pkg::RegPressB, CalTypB);
    write_cal(btpc_pkg::RegPressC, CalTypC);
    v.known = 1'b0;
    v.stim = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148}; vecs.push_back(v);
    v.stim = '{raw_temperature: 20'd0, raw_pressure: 20'd0};           vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF};   vecs.push_back(v);
    v.stim = '{raw_temperature: 20'd0, raw_pressure: 20'hFFFFF};       vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hFFFFF, raw_pressure: 20'd0};       vecs.push_back(v);
    v.stim = '{raw_temperature: 20'h55555, raw_pressure: 20'hAAAAA};   vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hAAAAA, raw_pressure: 20'h55555};   vecs.push_back(v);
    run_vecs();
    vecs.delete();
    drain();

    // large numerator path: negative offset pushes it past the half range
    write_cal(btpc_pkg::RegPressB, {16'h7FFF, 16'h8000, 16'h8000});
    write_cal(btpc_pkg::RegPressC, {16'h8000, 16'h7FFF, 16'h8000});
    v.stim = '{raw_temperature: 20'd519888, raw_pressure: 20'd0};   vecs.push_back(v);
    v.stim = '{raw_temperature: 20'hFFFFF, raw_pressure: 20'd100};  vecs.push_back(v);
    v.stim = '{raw_temperature: 20'd0, raw_pressure: 20'hFFFFF};    vecs.push_back(v);
    run_vecs();
    vecs.delete();
    random_phase(150);
    drain();

    // P1 zero gives a zero divisor with live temperature
    write_cal(btpc_pkg::RegPressA, {16'd3024, 16'hD4BC, 16'd0});
    v.known = 1'b0;
    v.stim = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148}; vecs.push_back(v);
    run_vecs();
    vecs.delete();
    random_phase(30);
    drain();

    // all-ones and all-max extremes
    write_cal(btpc_pkg::RegTemp, 48'hFFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressA, 48'hFFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressB, 48'hFFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressC, 48'hFFFF_FFFF_FFFF);
    random_phase(60);
    drain();
    write_cal(btpc_pkg::RegTemp, {16'h7FFF, 16'h7FFF, 16'hFFFF});
    write_cal(btpc_pkg::RegPressA, {16'h7FFF, 16'h7FFF, 16'hFFFF});
    write_cal(btpc_pkg::RegPressB, {16'h8000, 16'h7FFF, 16'h8000});
    write_cal(btpc_pkg::RegPressC, {16'h7FFF, 16'h8000, 16'h7FFF});
    random_phase(60);
    drain();

    // random calibrations, with one long receiver hold-off and back-to-back feed
    for (int p = 0; p < 4; p++) begin
      write_cal(btpc_pkg::RegTemp, 48'({$urandom(), $urandom()}));
      write_cal(btpc_pkg::RegPressA, 48'({$urandom(), $urandom()}));
      write_cal(btpc_pkg::RegPressB, 48'({$urandom(), $urandom()}));
      write_cal(btpc_pkg::RegPressC, 48'({$urandom(), $urandom()}));
      if (p == 1) begin
        hold_off = 1'b1;
        repeat (80) send_burst(rand_pair());
      end
      random_phase(50);
      drain();
    end

    // typical set again for the rest
    write_cal(btpc_pkg::RegTemp, CalTypT);
    write_cal(btpc_pkg::RegPressA, CalTypA);
    write_cal(btpc_pkg::RegPressB, CalTypB);
    write_cal(btpc_pkg::RegPressC, CalTypC);
    random_phase(60);
    drain();

    $display("covered %0d requests, %0d results (%0d with zero divisor) over 11 calibrations",
             n_sent, n_recv, n_invalid);
    if (errors == 0 && comp_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, comp_pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
